// ===== rtl/core/shortest_path_distance_matrix_top_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef SHORTEST_PATH_DISTANCE_MATRIX_TOP_DEFINES_SVH
`define SHORTEST_PATH_DISTANCE_MATRIX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/spd_pkg.sv =====
package spd_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_EDGES   = 4096;
	localparam int MAX_TARGETS = 64;
	localparam int HEAP_DEPTH  = MAX_EDGES + 1;

	localparam int NODE_W   = 10;
	localparam int DIST_W   = 48;
	localparam int COST_W   = 32;
	localparam int SLOT_W   = 13;
	localparam int FUNC_W   = 2;
	localparam int KEY_W    = DIST_W + NODE_W;
	localparam int NCNT_W   = 11;
	localparam int TCNT_W   = 7;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 11;
	localparam int OFFA_W   = $clog2(MAX_NODES + 1);
	localparam int EDGA_W   = $clog2(MAX_EDGES);
	localparam int TGTA_W   = $clog2(MAX_TARGETS);
	localparam int HEAPA_W  = $clog2(HEAP_DEPTH);
	localparam int EDGE_MW  = NODE_W + 2 * COST_W;
	localparam int NODE_MW  = 1 + 2 * DIST_W;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_OFFSET = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_EDGE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_TARGET = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY       = 2'd3;

	localparam logic [CIDX_W-1:0] CFG_NODE_COUNT   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TARGET_COUNT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_USE_SECOND   = 2'd2;

	// Keys are {distance, node}: one unsigned compare orders by distance, then node.
	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t a;
		key_t b;
	} alu_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] sum;
		logic              less;
	} alu_rsp_t;

endpackage

// ===== rtl/core/spd_alu.sv =====
module spd_alu (
	input  spd_pkg::alu_req_t req,
	output spd_pkg::alu_rsp_t rsp
);
	import spd_pkg::*;

	logic [DIST_W:0] sum_w;

	// Add the distance parts, clamp on carry out.
	assign sum_w    = {1'b0, req.a[KEY_W-1:NODE_W]} + {1'b0, req.b[KEY_W-1:NODE_W]};
	assign rsp.sum  = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];
	assign rsp.less = (req.a < req.b);

endmodule

// ===== rtl/core/shortest_path_distance_matrix_top.sv =====
// Single-source shortest path engine. Load items (func 0, 1, 2) write the offset, edge
// and target stores. A query item (func 3) first sweeps the 1024-entry per-node store,
// then runs Dijkstra on a binary min-heap in a heap memory with one read and one write
// port, with one shared saturating adder/comparator doing every distance sum and key
// compare. The input is not ready while a query runs. Results come out one per target,
// in list order, with last set on the final one; unreachable targets report all ones
// with unreachable set.
module shortest_path_distance_matrix_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [spd_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [spd_pkg::CDATA_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spd_pkg::FUNC_W-1:0]   func,
	input  logic [spd_pkg::SLOT_W-1:0]   entry_index,
	input  logic [spd_pkg::NODE_W-1:0]   node_id,
	input  logic [spd_pkg::SLOT_W-1:0]   edge_offset,
	input  logic [spd_pkg::COST_W-1:0]   weight_in,
	input  logic [spd_pkg::COST_W-1:0]   extra_cost_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spd_pkg::TGTA_W-1:0]   target_slot,
	output logic [spd_pkg::DIST_W-1:0]   distance,
	output logic                         unreachable,
	output logic                         last
);
	import spd_pkg::*;
	`include "shortest_path_distance_matrix_top_defines.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_START, S_POP0, S_POP1, S_POP2,
		S_SD_L, S_SD_LR, S_SD_R, S_SD_C1, S_SD_C2,
		S_CHK, S_CV2, S_CV3, S_CV4,
		S_EDGE, S_ED2, S_ED3, S_ED4, S_ED5,
		S_PU1, S_PU2,
		S_TGT, S_T2, S_T3, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [NCNT_W-1:0] node_count_q;
	logic [TCNT_W-1:0] target_count_q;
	logic              use_second_q;
	logic [NCNT_W-1:0] nodes_eff;
	logic [TCNT_W-1:0] count_eff;

	// stores
	logic [SLOT_W-1:0]  off_mem  [MAX_NODES+1];
	logic [EDGE_MW-1:0] edge_mem [MAX_EDGES];
	logic [NODE_W-1:0]  tgt_mem  [MAX_TARGETS];
	logic [NODE_MW-1:0] node_mem [MAX_NODES];
	key_t               heap_mem [HEAP_DEPTH];

	logic [SLOT_W-1:0]  off_rdata_q;
	logic [EDGE_MW-1:0] edge_rdata_q;
	logic [NODE_W-1:0]  tgt_rdata_q;
	logic [NODE_MW-1:0] node_rdata_q;
	key_t               hp_rdata_q;

	logic [OFFA_W-1:0]  off_raddr;
	logic [EDGA_W-1:0]  edge_raddr;
	logic [TGTA_W-1:0]  tgt_raddr;
	logic [NODE_W-1:0]  node_raddr, node_waddr;
	logic               node_we;
	logic [NODE_MW-1:0] node_wdata;
	logic [HEAPA_W-1:0] hp_raddr, hp_waddr;
	logic               hp_we;
	key_t               hp_wdata;

	// sequencer registers
	logic [NODE_W-1:0]  src_q;
	logic [NODE_W-1:0]  clr_q;
	logic [HEAPA_W-1:0] hp_size_q;
	logic [HEAPA_W-1:0] hi_q;
	logic [HEAPA_W-1:0] pi_q;
	logic [HEAPA_W-1:0] mi_q;
	key_t               hkey_q, lkey_q, rkey_q, mkey_q, popkey_q;
	logic               rvalid_q;
	logic [DIST_W-1:0]  bestv_q, secv_q, nd_q, besth_q;
	logic               reachh_q;
	logic [SLOT_W-1:0]  e_q, e1_q;
	logic [NODE_W-1:0]  h_q;
	logic [COST_W-1:0]  wt_q, xc_q;
	logic [TCNT_W-1:0]  tidx_q;
	logic               tok_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [HEAPA_W:0]   l_idx, r_idx;
	logic [NODE_W-1:0]  pop_node;
	logic [DIST_W-1:0]  pop_dist;
	logic               rless;
	logic [HEAPA_W-1:0] fin_mi;
	key_t               fin_mkey;
	logic [SLOT_W-1:0]  e1_cap;
	logic               tgt_ok;

	spd_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign nodes_eff = (node_count_q > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_q;
	assign count_eff = (target_count_q > TCNT_W'(MAX_TARGETS)) ?
		TCNT_W'(MAX_TARGETS) : target_count_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign l_idx    = {hi_q, 1'b1};
	assign r_idx    = l_idx + 1'b1;
	assign pop_node = popkey_q[NODE_W-1:0];
	assign pop_dist = popkey_q[KEY_W-1:NODE_W];
	assign rless    = rvalid_q && alu_rsp.less;
	assign fin_mi   = rless ? r_idx[HEAPA_W-1:0] : mi_q;
	assign fin_mkey = rless ? rkey_q : mkey_q;
	assign e1_cap   = (off_rdata_q > SLOT_W'(MAX_EDGES)) ? SLOT_W'(MAX_EDGES) : off_rdata_q;
	assign tgt_ok   = tok_q && node_rdata_q[NODE_MW-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= NCNT_W'(MAX_NODES);
			target_count_q <= TCNT_W'(1);
			use_second_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_COUNT:   node_count_q   <= cfg_data[NCNT_W-1:0];
				CFG_TARGET_COUNT: target_count_q <= cfg_data[TCNT_W-1:0];
				CFG_USE_SECOND:   use_second_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Load stores: written only by load requests while idle.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (func == FUNC_LOAD_OFFSET && entry_index <= SLOT_W'(MAX_NODES))
				off_mem[entry_index[OFFA_W-1:0]] <= edge_offset;
			if (func == FUNC_LOAD_EDGE && entry_index < SLOT_W'(MAX_EDGES))
				edge_mem[entry_index[EDGA_W-1:0]] <= {node_id, weight_in, extra_cost_in};
			if (func == FUNC_LOAD_TARGET && entry_index < SLOT_W'(MAX_TARGETS))
				tgt_mem[entry_index[TGTA_W-1:0]] <= node_id;
		end
		off_rdata_q  <= off_mem[off_raddr];
		edge_rdata_q <= edge_mem[edge_raddr];
		tgt_rdata_q  <= tgt_mem[tgt_raddr];
	end

	// Per-node store: {reached, best distance, path secondary cost}.
	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[node_waddr] <= node_wdata;
		node_rdata_q <= node_mem[node_raddr];
	end

	// Heap store.
	always_ff @(posedge clk) begin
		if (hp_we)
			heap_mem[hp_waddr] <= hp_wdata;
		hp_rdata_q <= heap_mem[hp_raddr];
	end

	// Memory ports and shared unit operands, steered by state.
	always_comb begin
		off_raddr  = OFFA_W'(pop_node);
		edge_raddr = e_q[EDGA_W-1:0];
		tgt_raddr  = tidx_q[TGTA_W-1:0];
		node_raddr = pop_node;
		node_we    = 1'b0;
		node_waddr = clr_q;
		node_wdata = {1'b0, DIST_MAX, DIST_MAX};
		hp_raddr   = '0;
		hp_we      = 1'b0;
		hp_waddr   = hi_q;
		hp_wdata   = hkey_q;
		alu_req.a  = hkey_q;
		alu_req.b  = hp_rdata_q;
		case (state_q)
			S_CLEAR: begin
				node_we = 1'b1;
			end
			S_START: begin
				node_waddr = src_q;
				node_wdata = {1'b1, {DIST_W{1'b0}}, {DIST_W{1'b0}}};
				node_we    = ({1'b0, src_q} < nodes_eff);
				hp_waddr   = '0;
				hp_wdata   = {{DIST_W{1'b0}}, src_q};
				hp_we      = node_we;
			end
			S_POP1: hp_raddr = hp_size_q - 1'b1;
			S_SD_L: begin
				hp_raddr = l_idx[HEAPA_W-1:0];
				hp_we    = !(l_idx < {1'b0, hp_size_q});
			end
			S_SD_LR: hp_raddr = r_idx[HEAPA_W-1:0];
			S_SD_C1: begin
				alu_req.a = lkey_q;
				alu_req.b = hkey_q;
			end
			S_SD_C2: begin
				alu_req.a = rkey_q;
				alu_req.b = mkey_q;
				hp_we     = 1'b1;
				hp_wdata  = (fin_mi == hi_q) ? hkey_q : fin_mkey;
			end
			S_CV2: begin
				alu_req.a = {node_rdata_q[NODE_MW-2:DIST_W], {NODE_W{1'b0}}};
				alu_req.b = {pop_dist, {NODE_W{1'b0}}};
			end
			S_CV3: off_raddr = OFFA_W'(pop_node) + 1'b1;
			S_ED2: node_raddr = edge_rdata_q[EDGE_MW-1:2*COST_W];
			S_ED3: begin
				alu_req.a = {bestv_q, {NODE_W{1'b0}}};
				alu_req.b = {{(DIST_W-COST_W){1'b0}}, wt_q, {NODE_W{1'b0}}};
			end
			S_ED4: begin
				alu_req.a = {nd_q, {NODE_W{1'b0}}};
				alu_req.b = {besth_q, {NODE_W{1'b0}}};
			end
			S_ED5: begin
				alu_req.a  = {secv_q, {NODE_W{1'b0}}};
				alu_req.b  = {{(DIST_W-COST_W){1'b0}}, xc_q, {NODE_W{1'b0}}};
				node_we    = 1'b1;
				node_waddr = h_q;
				node_wdata = {1'b1, nd_q, alu_rsp.sum};
			end
			S_PU1: begin
				hp_raddr = (hi_q - 1'b1) >> 1;
				hp_we    = (hi_q == '0);
			end
			S_PU2: begin
				hp_we    = 1'b1;
				hp_wdata = alu_rsp.less ? hp_rdata_q : hkey_q;
			end
			S_T2: node_raddr = tgt_rdata_q;
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hp_size_q   <= '0;
			out_valid   <= 1'b0;
			clr_q       <= '0;
			tidx_q      <= '0;
			src_q       <= '0;
			hi_q        <= '0;
			pi_q        <= '0;
			mi_q        <= '0;
			e_q         <= '0;
			e1_q        <= '0;
			rvalid_q    <= 1'b0;
			tok_q       <= 1'b0;
			target_slot <= '0;
			distance    <= '0;
			unreachable <= 1'b0;
			last        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && func == FUNC_QUERY) begin
						src_q   <= node_id;
						clr_q   <= '0;
						tidx_q  <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NODE_W'(MAX_NODES - 1))
						state_q <= S_START;
				end
				S_START: begin
					if ({1'b0, src_q} < nodes_eff) begin
						hp_size_q <= HEAPA_W'(1);
						state_q   <= S_POP0;
					end else begin
						state_q <= S_TGT;
					end
				end
				S_POP0: state_q <= (hp_size_q == '0) ? S_TGT : S_POP1;
				S_POP1: begin
					popkey_q  <= hp_rdata_q;
					hp_size_q <= hp_size_q - 1'b1;
					state_q   <= S_POP2;
				end
				S_POP2: begin
					hkey_q  <= hp_rdata_q;
					hi_q    <= '0;
					state_q <= S_SD_L;
				end
				S_SD_L: state_q <= (l_idx < {1'b0, hp_size_q}) ? S_SD_LR : S_CHK;
				S_SD_LR: begin
					lkey_q   <= hp_rdata_q;
					rvalid_q <= (r_idx < {1'b0, hp_size_q});
					state_q  <= S_SD_R;
				end
				S_SD_R: begin
					rkey_q  <= hp_rdata_q;
					state_q <= S_SD_C1;
				end
				S_SD_C1: begin
					mkey_q  <= alu_rsp.less ? lkey_q : hkey_q;
					mi_q    <= alu_rsp.less ? l_idx[HEAPA_W-1:0] : hi_q;
					state_q <= S_SD_C2;
				end
				S_SD_C2: begin
					if (fin_mi == hi_q) begin
						state_q <= S_CHK;
					end else begin
						hi_q    <= fin_mi;
						state_q <= S_SD_L;
					end
				end
				S_CHK: state_q <= ({1'b0, pop_node} < nodes_eff) ? S_CV2 : S_POP0;
				S_CV2: begin
					// drop stale entries whose key exceeds the settled distance
					bestv_q <= node_rdata_q[NODE_MW-2:DIST_W];
					secv_q  <= node_rdata_q[DIST_W-1:0];
					state_q <= alu_rsp.less ? S_POP0 : S_CV3;
				end
				S_CV3: begin
					// first edge offset of the popped node is on the read port now
					e_q     <= off_rdata_q;
					state_q <= S_CV4;
				end
				S_CV4: state_q <= S_EDGE;
				S_EDGE: begin
					if (state_q == S_EDGE && e_q < e1_q)
						state_q <= S_ED2;
					else
						state_q <= S_POP0;
				end
				S_ED2: begin
					h_q  <= edge_rdata_q[EDGE_MW-1:2*COST_W];
					wt_q <= edge_rdata_q[2*COST_W-1:COST_W];
					xc_q <= edge_rdata_q[COST_W-1:0];
					if ({1'b0, edge_rdata_q[EDGE_MW-1:2*COST_W]} < nodes_eff) begin
						state_q <= S_ED3;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_ED3: begin
					nd_q     <= alu_rsp.sum;
					besth_q  <= node_rdata_q[NODE_MW-2:DIST_W];
					reachh_q <= node_rdata_q[NODE_MW-1];
					state_q  <= S_ED4;
				end
				S_ED4: begin
					if (!reachh_q || alu_rsp.less) begin
						state_q <= S_ED5;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_ED5: begin
					if (hp_size_q >= HEAPA_W'(HEAP_DEPTH)) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end else begin
						hi_q      <= hp_size_q;
						hp_size_q <= hp_size_q + 1'b1;
						hkey_q    <= {nd_q, h_q};
						state_q   <= S_PU1;
					end
				end
				S_PU1: begin
					if (hi_q == '0) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end else begin
						pi_q    <= (hi_q - 1'b1) >> 1;
						state_q <= S_PU2;
					end
				end
				S_PU2: begin
					if (alu_rsp.less) begin
						hi_q    <= pi_q;
						state_q <= S_PU1;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_TGT: state_q <= (tidx_q < count_eff) ? S_T2 : S_IDLE;
				S_T2: begin
					tok_q   <= ({1'b0, tgt_rdata_q} < nodes_eff);
					state_q <= S_T3;
				end
				S_T3: begin
					target_slot <= tidx_q[TGTA_W-1:0];
					unreachable <= !tgt_ok;
					last        <= (tidx_q + 1'b1 == count_eff);
					if (!tgt_ok)
						distance <= DIST_MAX;
					else if (use_second_q)
						distance <= node_rdata_q[DIST_W-1:0];
					else
						distance <= node_rdata_q[NODE_MW-2:DIST_W];
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						tidx_q    <= tidx_q + 1'b1;
						state_q   <= S_TGT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_CV4)
				e1_q <= e1_cap;
		end
	end

	`SPD_ASSERT_NOW(a_heap_bound, clk, arst_n, 1'b1, hp_size_q <= HEAPA_W'(HEAP_DEPTH), "heap overflow")
	`SPD_ASSERT_NOW(a_idle_empty, clk, arst_n, state_q == S_IDLE, hp_size_q == '0, "heap not empty at idle")
	`SPD_ASSERT_NOW(a_out_excl, clk, arst_n, out_valid, !in_ready, "input open while result pending")
	`SPD_ASSERT_NEXT(a_query_clear, clk, arst_n, in_valid && in_ready && func == FUNC_QUERY, state_q == S_CLEAR && clr_q == '0, "query did not start sweep")

endmodule

// ===== tb/spd_checker.sv =====
module spd_checker
	import spd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDATA_W-1:0]  cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [SLOT_W-1:0]   entry_index,
	input  logic [NODE_W-1:0]   node_id,
	input  logic [SLOT_W-1:0]   edge_offset,
	input  logic [COST_W-1:0]   weight_in,
	input  logic [COST_W-1:0]   extra_cost_in,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [TGTA_W-1:0]   target_slot,
	input  logic [DIST_W-1:0]   distance,
	input  logic                unreachable,
	input  logic                last,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [TGTA_W-1:0] slot;
		logic [DIST_W-1:0] dval;
		logic              unr;
		logic              lst;
	} report_t;

	report_t reports_due[$];

	logic [SLOT_W-1:0] offs [0:MAX_NODES];
	logic [NODE_W-1:0] head [0:MAX_EDGES-1];
	logic [COST_W-1:0] wgt  [0:MAX_EDGES-1];
	logic [COST_W-1:0] xtra [0:MAX_EDGES-1];
	logic [NODE_W-1:0] tgt  [0:MAX_TARGETS-1];

	logic [DIST_W-1:0] best [0:MAX_NODES-1];
	logic [DIST_W-1:0] psec [0:MAX_NODES-1];
	bit                seen [0:MAX_NODES-1];
	logic [DIST_W-1:0] hdist [0:HEAP_DEPTH-1];
	int unsigned       hnode [0:HEAP_DEPTH-1];
	int unsigned       hsz;

	int unsigned ncount, tcount;
	bit          use_sec;

	function automatic logic [DIST_W-1:0] sat_sum(input logic [DIST_W-1:0] a,
			input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

	function automatic bit key_lt(input int unsigned a, input int unsigned b);
		if (hdist[a] != hdist[b])
			return hdist[a] < hdist[b];
		return hnode[a] < hnode[b];
	endfunction

	function automatic void key_swap(input int unsigned a, input int unsigned b);
		logic [DIST_W-1:0] d;
		int unsigned n;
		d = hdist[a];
		n = hnode[a];
		hdist[a] = hdist[b];
		hnode[a] = hnode[b];
		hdist[b] = d;
		hnode[b] = n;
	endfunction

	function automatic void heap_push(input logic [DIST_W-1:0] d, input int unsigned n);
		int unsigned i, p;
		// drop the entry when the heap is full
		if (hsz >= HEAP_DEPTH)
			return;
		i = hsz;
		hsz++;
		hdist[i] = d;
		hnode[i] = n;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!key_lt(i, p))
				break;
			key_swap(i, p);
			i = p;
		end
	endfunction

	function automatic void heap_pop(output logic [DIST_W-1:0] d, output int unsigned n);
		int unsigned i, l, r, m;
		d = hdist[0];
		n = hnode[0];
		hsz--;
		hdist[0] = hdist[hsz];
		hnode[0] = hnode[hsz];
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < hsz && key_lt(l, m))
				m = l;
			if (r < hsz && key_lt(r, m))
				m = r;
			if (m == i)
				break;
			key_swap(i, m);
			i = m;
		end
	endfunction

	function automatic void solve_query(input int unsigned src);
		int unsigned nodes, cnt, v, e, e0, e1, h, t;
		logic [DIST_W-1:0] w, nd;
		bit ok;
		report_t r;
		nodes = (ncount > MAX_NODES) ? MAX_NODES : ncount;
		cnt = (tcount > MAX_TARGETS) ? MAX_TARGETS : tcount;
		for (int i = 0; i < MAX_NODES; i++) begin
			best[i] = DIST_MAX;
			psec[i] = DIST_MAX;
			seen[i] = 1'b0;
		end
		hsz = 0;
		if (src < nodes) begin
			best[src] = '0;
			psec[src] = '0;
			seen[src] = 1'b1;
			heap_push('0, src);
			while (hsz > 0) begin
				heap_pop(w, v);
				// skip stale heap entries
				if (v < nodes && w <= best[v]) begin
					e0 = offs[v];
					e1 = offs[v + 1];
					if (e1 > MAX_EDGES)
						e1 = MAX_EDGES;
					for (e = e0; e < e1; e++) begin
						h = head[e];
						if (h < nodes) begin
							nd = sat_sum(best[v], DIST_W'(wgt[e]));
							if (!seen[h] || nd < best[h]) begin
								seen[h] = 1'b1;
								best[h] = nd;
								psec[h] = sat_sum(psec[v], DIST_W'(xtra[e]));
								heap_push(nd, h);
							end
						end
					end
				end
			end
		end
		for (int i = 0; i < cnt; i++) begin
			t = tgt[i];
			ok = (t < nodes) && seen[t];
			r.slot = i[TGTA_W-1:0];
			r.dval = ok ? (use_sec ? psec[t] : best[t]) : DIST_MAX;
			r.unr = !ok;
			r.lst = (i + 1 == cnt);
			reports_due.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t exp_r, got_r;
		if (!arst_n) begin
			ncount = MAX_NODES;
			tcount = 1;
			use_sec = 1'b0;
			reports_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NODE_COUNT: ncount = cfg_data;
					CFG_TARGET_COUNT: tcount = cfg_data[TCNT_W-1:0];
					CFG_USE_SECOND: use_sec = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (func)
					FUNC_LOAD_OFFSET: if (entry_index <= MAX_NODES) offs[entry_index] = edge_offset;
					FUNC_LOAD_EDGE: begin
						if (entry_index < MAX_EDGES) begin
							head[entry_index] = node_id;
							wgt[entry_index] = weight_in;
							xtra[entry_index] = extra_cost_in;
						end
					end
					FUNC_LOAD_TARGET: if (entry_index < MAX_TARGETS) tgt[entry_index] = node_id;
					default: solve_query(node_id);
				endcase
			end
			if (out_valid && out_ready) begin
				got_r = '{target_slot, distance, unreachable, last};
				if (reports_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result slot %0d distance %h unreachable %b last %b",
						$time, target_slot, distance, unreachable, last);
				end else begin
					exp_r = reports_due.pop_front();
					if (got_r !== exp_r) begin
						fail_count++;
						$display("%0t: expected slot %0d distance %h unreachable %b last %b",
							$time, exp_r.slot, exp_r.dval, exp_r.unr, exp_r.lst);
						$display("%0t: actual   slot %0d distance %h unreachable %b last %b",
							$time, got_r.slot, got_r.dval, got_r.unr, got_r.lst);
					end
				end
			end
		end
		pending = reports_due.size();
	end

endmodule

// ===== tb/tb_shortest_path_distance_matrix_top.sv =====
module tb_shortest_path_distance_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spd_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [CDATA_W-1:0]  cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [SLOT_W-1:0]   entry_index = '0;
	logic [NODE_W-1:0]   node_id = '0;
	logic [SLOT_W-1:0]   edge_offset = '0;
	logic [COST_W-1:0]   weight_in = '0;
	logic [COST_W-1:0]   extra_cost_in = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [TGTA_W-1:0]   target_slot;
	logic [DIST_W-1:0]   distance;
	logic                unreachable;
	logic                last;

	int fail_count;
	int pending;
	// calm: no idling on either side; stall_req: one long output hold-off
	bit calm = 1'b0;
	bit stall_req = 1'b0;
	int unsigned cycles = 0;

	localparam int IDLE_PCT  = 38;
	localparam int SETTLE    = 20;      // let the block sit idle before reconfiguring
	localparam int HOLD_OFF  = 4000;
	localparam int CYCLE_CAP = 6000000;

	// register index with no register behind it
	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

	shortest_path_distance_matrix_top DUT (.*);

	spd_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Output side: random backpressure, plus one long hold-off while the sender keeps
	// pushing, so the block holds its pending result and stalls its input.
	initial begin
		bit stalled;
		stalled = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_req && !stalled) begin
				stalled = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one request and hold it until accepted. Valid drops only on an idle gap,
	// so back-to-back requests never toggle it within one step.
	task automatic send_req(input logic [FUNC_W-1:0] f, input int unsigned idx,
			input int unsigned nid, input int unsigned off, input logic [COST_W-1:0] w,
			input logic [COST_W-1:0] x);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_index <= idx[SLOT_W-1:0];
		node_id <= nid[NODE_W-1:0];
		edge_offset <= off[SLOT_W-1:0];
		weight_in <= w;
		extra_cost_in <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid, wait out every expected result and the end of the query, then settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		while (!in_ready) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CDATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COST_W-1:0] pick_weight();
		// zero and small equal weights make ties common; one pick spans the full range
		case ($urandom_range(3))
			0: return '0;
			1: return COST_W'($urandom_range(1, 3)) << 8;
			2: return COST_W'($urandom_range(1, 255));
			default: return $urandom();
		endcase
	endfunction

	// Load a random graph over nodes 0..n-1 in adjacency order, plus all targets.
	task automatic build_graph(input int unsigned n);
		int unsigned edges, deg, hd, v;
		edges = 0;
		for (int i = 0; i < n; i++) begin
			send_req(FUNC_LOAD_OFFSET, i, $urandom(), edges, $urandom(), $urandom());
			deg = $urandom_range(0, 4);
			for (int k = 0; k < deg; k++) begin
				hd = ($urandom_range(99) < 10) ? $urandom_range(1023) : $urandom_range(n - 1);
				send_req(FUNC_LOAD_EDGE, edges, hd, $urandom(), pick_weight(), $urandom());
				edges++;
			end
		end
		send_req(FUNC_LOAD_OFFSET, n, $urandom(), edges, $urandom(), $urandom());
		case ($urandom_range(3))
			0: begin
				// end offset past the edge store: the last node walks the top slots
				send_req(FUNC_LOAD_OFFSET, n - 1, 0, MAX_EDGES - 6, 0, 0);
				send_req(FUNC_LOAD_OFFSET, n, 0, 8191, 0, 0);
			end
			1: begin
				// inverted range for one node
				v = $urandom_range(n - 1);
				send_req(FUNC_LOAD_OFFSET, v, 0, edges + 2, 0, 0);
			end
			default: ;
		endcase
		for (int t = 0; t < MAX_TARGETS; t++) begin
			hd = ($urandom_range(99) < 15) ? $urandom_range(1023) : $urandom_range(n - 1);
			send_req(FUNC_LOAD_TARGET, t, hd, $urandom(), $urandom(), $urandom());
		end
		// loads beyond each store depth are dropped by the block
		send_req(FUNC_LOAD_OFFSET, $urandom_range(MAX_NODES + 1, 8191), $urandom(),
			$urandom_range(8191), $urandom(), $urandom());
		send_req(FUNC_LOAD_EDGE, $urandom_range(MAX_EDGES, 8191), $urandom(), $urandom(),
			$urandom(), $urandom());
		send_req(FUNC_LOAD_TARGET, $urandom_range(MAX_TARGETS, 8191), $urandom(), $urandom(),
			$urandom(), $urandom());
	endtask

	task automatic run_phase(input int unsigned ncfg, input int unsigned n,
			input int unsigned tcfg, input bit sec, input int unsigned nq);
		int unsigned src;
		write_reg(CFG_NODE_COUNT, ncfg);
		write_reg(CFG_TARGET_COUNT, tcfg);
		write_reg(CFG_USE_SECOND, sec);
		build_graph(n);
		for (int q = 0; q < nq; q++) begin
			// mostly in-range sources; n itself and wide picks can land out of range
			src = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n);
			send_req(FUNC_QUERY, $urandom(), src, $urandom(), $urandom(), $urandom());
		end
		drain();
	endtask

	initial begin
		int unsigned n, ncfg, tcfg;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every load store once so no query ever reads an unwritten load entry.
		calm = 1'b1;
		for (int i = 0; i <= MAX_NODES; i++)
			send_req(FUNC_LOAD_OFFSET, i, $urandom(), 0, $urandom(), $urandom());
		for (int i = 0; i < MAX_EDGES; i++)
			send_req(FUNC_LOAD_EDGE, i, $urandom(), $urandom(), $urandom(), $urandom());
		for (int i = 0; i < MAX_TARGETS; i++)
			send_req(FUNC_LOAD_TARGET, i, $urandom(), $urandom(), $urandom(), $urandom());
		calm = 1'b0;
		drain();

		// Directed: one node, saturating counts, no targets, full node range.
		run_phase(1, 1, 1, 1'b0, 3);
		run_phase(2047, 16, 127, 1'b1, 3);
		run_phase(20, 20, 0, 1'b0, 2);
		run_phase(MAX_NODES, 30, MAX_TARGETS, 1'b1, 4);
		write_reg(CFG_SPARE, $urandom_range(2047));
		run_phase(24, 24, 64, 1'b0, 3);

		// Random phases: one without idling, one with the long output hold-off.
		for (int p = 0; p < 8; p++) begin
			n = $urandom_range(2, 24);
			ncfg = ($urandom_range(9) == 0) ? $urandom_range(MAX_NODES, 2047) : n;
			case ($urandom_range(9))
				0: tcfg = 0;
				1: tcfg = $urandom_range(MAX_TARGETS, 127);
				default: tcfg = $urandom_range(1, MAX_TARGETS);
			endcase
			calm = (p == 2);
			if (p == 4)
				stall_req = 1'b1;
			run_phase(ncfg, n, tcfg, $urandom_range(1), 11);
		end

		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
